[hw/rtl/fhnb_pkg.sv]
package fhnb_pkg;

	localparam int unsigned MAX_DIM = 4096;
	localparam int unsigned DIM_W   = 13;   // holds 1..MAX_DIM
	localparam int unsigned COORD_W = 12;   // holds 0..MAX_DIM-1
	localparam int unsigned COUNT_W = 25;
	localparam int unsigned HASH_W  = 64;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	// FNV-64 prime is 2^40 + 0x1B3: shift plus a 9-bit multiply
	localparam int unsigned      FNV_SHIFT = 40;
	localparam logic [8:0]       FNV_LOW   = 9'h1B3;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PBYTES = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic init;   // load offset basis
		logic step;   // fold one byte
	} hash_ctrl_t;

	typedef struct packed {
		logic upd;      // pixel accepted
		logic nonzero;  // pixel has a used nonzero byte
		logic clr;      // frame summary taken, start over
	} trk_ctrl_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               seen;
		logic [COORD_W-1:0] min_x;
		logic [COORD_W-1:0] min_y;
		logic [DIM_W-1:0]   end_x;
		logic [DIM_W-1:0]   end_y;
	} trk_sum_t;

endpackage

[hw/rtl/frame_hash_nonzero_bounds.sv]
// Flow: a pixel item is taken while idle, then hashed one byte per cycle
//   through a single FNV step unit.
// After a frame's last pixel, the emit state loads the summary into the output
//   register, and waits while that register is still held by the downstream side.
// Items do not overlap: s_tready stays low while the shared byte-step unit folds an item.
// Reset: arst_n async, active low; width 1, height 1, 4-byte pixels, FNV basis, rest zero.
module frame_hash_nonzero_bounds import fhnb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	// pixel stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [31:0]   s_tdata,   // [31:0] pixel_value
	// summary stream
	output logic          m_tvalid,
	input  logic          m_tready,
	// [63:0] frame_hash, [88:64] nonzero_count, [89] box_valid,
	// [101:90] box_min_x, [113:102] box_min_y, [126:114] box_end_x,
	// [139:127] box_end_y, [143:140] zero
	output logic [143:0]  m_tdata,
	// configuration
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_EMIT
	} state_t;

	// ---------------- configuration registers ----------------
	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [2:0]       pixel_bytes_q;
	reg_idx_t         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(1);
			frame_height_q <= DIM_W'(1);
			pixel_bytes_q  <= 3'd4;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
				REG_PBYTES: pixel_bytes_q  <= pwdata[2:0];
				default: ;  // unmapped, ignored
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, frame_width_q};
			REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, frame_height_q};
			REG_PBYTES: prdata = {29'b0, pixel_bytes_q};
			default:    prdata = '0;
		endcase
	end

	// ---------------- clamped settings ----------------
	// 0 acts as 1, anything past the limit acts as the limit
	logic [DIM_W-1:0] width_eff, height_eff;
	logic [1:0]       last_byte;   // bytes per pixel minus one

	always_comb begin
		if (frame_width_q == '0)                width_eff = DIM_W'(1);
		else if (frame_width_q > DIM_W'(MAX_DIM)) width_eff = DIM_W'(MAX_DIM);
		else                                    width_eff = frame_width_q;

		if (frame_height_q == '0)                 height_eff = DIM_W'(1);
		else if (frame_height_q > DIM_W'(MAX_DIM)) height_eff = DIM_W'(MAX_DIM);
		else                                      height_eff = frame_height_q;

		if (pixel_bytes_q == 3'd0)      last_byte = 2'd0;
		else if (pixel_bytes_q > 3'd4)  last_byte = 2'd3;
		else                            last_byte = 2'(pixel_bytes_q - 3'd1);
	end

	// nonzero test over the used bytes only
	logic nonzero;
	always_comb begin
		case (last_byte)
			2'd0:    nonzero = |s_tdata[7:0];
			2'd1:    nonzero = |s_tdata[15:0];
			2'd2:    nonzero = |s_tdata[23:0];
			default: nonzero = |s_tdata;
		endcase
	end

	// ---------------- sequencer ----------------
	state_t            state_q;
	logic [31:0]       pix_q;        // byte 0 sits in [7:0], shifted down per step
	logic [1:0]        left_q;       // bytes still to fold after this one
	logic              fend_q;       // current pixel closes the frame
	logic              out_valid_q;
	logic [143:0]      out_q;
	logic              take;
	logic              out_free;
	logic              frame_end;
	logic [HASH_W-1:0] hash;
	trk_sum_t          sum;
	hash_ctrl_t        hash_ctrl;
	trk_ctrl_t         trk_ctrl;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		hash_ctrl.step   = (state_q == ST_HASH);
		hash_ctrl.init   = (state_q == ST_EMIT) && out_free;
		trk_ctrl.upd     = take;
		trk_ctrl.nonzero = nonzero;
		trk_ctrl.clr     = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pix_q       <= '0;
			left_q      <= '0;
			fend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// emit state reloads the register itself
			if (out_valid_q && m_tready && (state_q != ST_EMIT)) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						pix_q   <= s_tdata;
						left_q  <= last_byte;
						fend_q  <= frame_end;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					pix_q <= {8'b0, pix_q[31:8]};
					if (left_q == 2'd0) begin
						state_q <= fend_q ? ST_EMIT : ST_IDLE;
					end else begin
						left_q <= left_q - 2'd1;
					end
				end
				ST_EMIT: begin
					// hash already holds the frame's last byte
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= {4'b0, sum.end_y, sum.end_x, sum.min_y, sum.min_x,
							sum.seen, sum.count, hash};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	fhnb_hash_unit u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hash_ctrl),
		.data   (pix_q[7:0]),
		.hash   (hash)
	);

	fhnb_frame_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (trk_ctrl),
		.width     (width_eff),
		.height    (height_eff),
		.frame_end (frame_end),
		.sum       (sum)
	);

endmodule

[hw/rtl/fhnb_hash_unit.sv]
module fhnb_hash_unit import fhnb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  hash_ctrl_t        ctrl,
	input  logic [7:0]        data,
	output logic [HASH_W-1:0] hash
);

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] mix;
	logic [HASH_W-1:0] mul_lo;
	logic [HASH_W-1:0] next;

	// one FNV-1a byte step: xor, then multiply by the prime mod 2^64
	always_comb begin
		mix    = hash_q ^ {{(HASH_W-8){1'b0}}, data};
		mul_lo = mix * {{(HASH_W-9){1'b0}}, FNV_LOW};
		next   = mul_lo + {mix[HASH_W-FNV_SHIFT-1:0], {FNV_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (ctrl.init) begin
			hash_q <= FNV_BASIS;
		end else if (ctrl.step) begin
			hash_q <= next;
		end
	end

	assign hash = hash_q;

endmodule

[hw/rtl/fhnb_frame_track.sv]
module fhnb_frame_track import fhnb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  trk_ctrl_t        ctrl,
	input  logic [DIM_W-1:0] width,    // clamped
	input  logic [DIM_W-1:0] height,   // clamped
	output logic             frame_end,
	output trk_sum_t         sum
);

	logic [COORD_W-1:0] col_q, row_q;
	logic [COUNT_W-1:0] count_q;
	logic               seen_q;
	logic [COORD_W-1:0] min_x_q, min_y_q;
	logic [DIM_W-1:0]   end_x_q, end_y_q;
	logic [DIM_W-1:0]   x1, y1;
	logic               row_end;

	assign x1        = {1'b0, col_q} + DIM_W'(1);
	assign y1        = {1'b0, row_q} + DIM_W'(1);
	assign row_end   = x1 >= width;
	assign frame_end = row_end && (y1 >= height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			seen_q  <= 1'b0;
			min_x_q <= '0;
			min_y_q <= '0;
			end_x_q <= '0;
			end_y_q <= '0;
		end else if (ctrl.clr) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			seen_q  <= 1'b0;
			min_x_q <= '0;
			min_y_q <= '0;
			end_x_q <= '0;
			end_y_q <= '0;
		end else if (ctrl.upd) begin
			if (ctrl.nonzero) begin
				count_q <= count_q + COUNT_W'(1);
				seen_q  <= 1'b1;
				if (!seen_q) begin
					min_x_q <= col_q;
					min_y_q <= row_q;
					end_x_q <= x1;
					end_y_q <= y1;
				end else begin
					if (col_q < min_x_q) min_x_q <= col_q;
					if (row_q < min_y_q) min_y_q <= row_q;
					if (x1 > end_x_q) end_x_q <= x1;
					if (y1 > end_y_q) end_y_q <= y1;
				end
			end
			// raster walk; frame end wraps both counters
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	always_comb begin
		sum.count = count_q;
		sum.seen  = seen_q;
		sum.min_x = min_x_q;
		sum.min_y = min_y_q;
		sum.end_x = end_x_q;
		sum.end_y = end_y_q;
	end

endmodule
